/* sv/uf_pkg.sv */
package uf_pkg;

    typedef enum logic [1:0] {
        KIND_BUS_RD  = 2'd0,
        KIND_BUS_WR  = 2'd1,
        KIND_RX_PUSH = 2'd2,
        KIND_TX_POP  = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DATA = 1'b1
    } t_state;

    localparam logic [11:0] DATA_OFFSET    = 12'd0;
    localparam logic [11:0] STATUS_OFFSET  = 12'd4;
    localparam logic [7:0]  STATUS_TX_ROOM = 8'h01;
    localparam logic [7:0]  STATUS_RX_DATA = 8'h02;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_req;

    typedef struct packed {
        logic full;
        logic empty;
        logic empty_next;   // empty once this cycle's request has taken effect
        logic popped;
    } t_fifo_stat;

endpackage

/* sv/uf_ram.sv */
module uf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/uf_fifo.sv */
module uf_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  uf_pkg::t_fifo_req    i_req,
    input  logic [7:0]           i_wdata,
    output uf_pkg::t_fifo_stat   o_stat,
    output logic [7:0]           o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] w_tail_sum;
    logic [SW-1:0] w_tail_wrap;
    logic [AW-1:0] w_tail;
    logic          w_full, w_empty, w_push_ok, w_pop_ok;

    assign w_full    = (r_count == DEPTH_C);
    assign w_empty   = (r_count == '0);
    assign w_push_ok = i_req.push && !w_full;
    assign w_pop_ok  = i_req.pop && !w_empty;

    // tail = head + count, folded back once into the ring
    assign w_tail_sum  = SW'(r_head) + SW'(r_count);
    assign w_tail_wrap = (w_tail_sum >= DEPTH_S) ? (w_tail_sum - DEPTH_S) : w_tail_sum;
    assign w_tail      = w_tail_wrap[AW-1:0];

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (w_push_ok) begin
            n_count = r_count + CW'(1);
        end
        if (w_pop_ok) begin
            n_count = r_count - CW'(1);
            n_head  = (r_head == LAST_A) ? '0 : r_head + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // read port sits on the head; data appears the cycle after a pop
    uf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push_ok),
        .i_waddr (w_tail),
        .i_wdata (i_wdata),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    assign o_stat.full       = w_full;
    assign o_stat.empty      = w_empty;
    assign o_stat.empty_next = (n_count == '0);
    assign o_stat.popped     = w_pop_ok;

endmodule

/* sv/uart_fifo_register_model_unit.sv */
// A transfer accepted in ST_IDLE passes through ST_DATA before its result is registered
// for the master side; no new transfer is taken in ST_DATA, which waits on the FIFO RAM
// registered read of the popped byte, nor in ST_IDLE while an untaken result is held.
// Reset: i_rst_n synchronous, active low; clears both FIFO pointers and counts
// and the output valid. FIFO RAM contents are not cleared.
module uart_fifo_register_model_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] reg_offset, [15:12] access_len, [23:16] write_byte, [31:24] rx_byte
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] read_byte, [15:8] tx_byte, [16] tx_byte_valid, [17] byte_dropped,
    // [18] tx_pending, [19] rx_pending, [23:20] zero
    output logic [23:0] o_m_axis_tdata
);

    uf_pkg::t_state r_state, n_state;

    uf_pkg::t_kind      w_kind;
    logic [11:0]        w_offset;
    logic [3:0]         w_len;
    logic [7:0]         w_write_byte;
    logic [7:0]         w_rx_byte;
    logic               w_accept, w_ready, w_load, w_bus_ok;
    uf_pkg::t_fifo_req  w_rx_req, w_tx_req;
    uf_pkg::t_fifo_stat w_rx_stat, w_tx_stat;
    logic [7:0]         w_rx_rdata, w_tx_rdata;
    logic [7:0]         w_status;

    // per-item results held until the RAM data arrives
    logic       r_rx_popped, r_tx_popped, r_dropped, r_tx_pend, r_rx_pend;
    logic [7:0] r_status;

    logic       r_out_valid;
    logic [7:0] r_read_byte, r_tx_byte;
    logic       r_tx_valid, r_out_dropped, r_out_tx_pend, r_out_rx_pend;

    assign w_kind       = uf_pkg::t_kind'(i_s_axis_tuser);
    assign w_offset     = i_s_axis_tdata[11:0];
    assign w_len        = i_s_axis_tdata[15:12];
    assign w_write_byte = i_s_axis_tdata[23:16];
    assign w_rx_byte    = i_s_axis_tdata[31:24];

    assign w_accept = i_s_axis_tvalid && w_ready;
    assign w_bus_ok = (w_len != 4'd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            uf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = uf_pkg::ST_DATA;
                end
            end
            uf_pkg::ST_DATA: begin
                n_state = uf_pkg::ST_IDLE;
            end
            default: begin
                n_state = uf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ready = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            uf_pkg::ST_IDLE: begin
                w_ready = !r_out_valid || i_m_axis_tready;
            end
            uf_pkg::ST_DATA: begin
                w_load = 1'b1;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_rx_req.push = w_accept && (w_kind == uf_pkg::KIND_RX_PUSH);
        w_rx_req.pop  = w_accept && (w_kind == uf_pkg::KIND_BUS_RD) && w_bus_ok
                        && (w_offset == uf_pkg::DATA_OFFSET);
        w_tx_req.push = w_accept && (w_kind == uf_pkg::KIND_BUS_WR) && w_bus_ok
                        && (w_offset == uf_pkg::DATA_OFFSET);
        w_tx_req.pop  = w_accept && (w_kind == uf_pkg::KIND_TX_POP);
    end

    always_comb begin
        w_status = 8'h00;
        if ((w_kind == uf_pkg::KIND_BUS_RD) && w_bus_ok
                && (w_offset == uf_pkg::STATUS_OFFSET)) begin
            if (!w_tx_stat.full) begin
                w_status = w_status | uf_pkg::STATUS_TX_ROOM;
            end
            if (!w_rx_stat.empty) begin
                w_status = w_status | uf_pkg::STATUS_RX_DATA;
            end
        end
    end

    uf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rx_req),
        .i_wdata (w_rx_byte),
        .o_stat  (w_rx_stat),
        .o_rdata (w_rx_rdata)
    );

    uf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tx_req),
        .i_wdata (w_write_byte),
        .o_stat  (w_tx_stat),
        .o_rdata (w_tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= uf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rx_popped <= w_rx_stat.popped;
            r_tx_popped <= w_tx_stat.popped;
            r_dropped   <= (w_rx_req.push && w_rx_stat.full)
                           || (w_tx_req.push && w_tx_stat.full);
            r_tx_pend   <= !w_tx_stat.empty_next;
            r_rx_pend   <= !w_rx_stat.empty_next;
            r_status    <= w_status;
        end
        if (w_load) begin
            r_read_byte   <= r_rx_popped ? w_rx_rdata : r_status;
            r_tx_byte     <= r_tx_popped ? w_tx_rdata : 8'h00;
            r_tx_valid    <= r_tx_popped;
            r_out_dropped <= r_dropped;
            r_out_tx_pend <= r_tx_pend;
            r_out_rx_pend <= r_rx_pend;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'h0, r_out_rx_pend, r_out_tx_pend, r_out_dropped,
                              r_tx_valid, r_tx_byte, r_read_byte};

endmodule

/* sim/uart_fifo_register_model_unit_tb.sv */
module uart_fifo_register_model_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int N_ITEMS     = 450;
    localparam int CALM_TAIL   = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        uf_pkg::t_kind kind;
        logic [11:0]   offset;
        logic [3:0]    len;
        logic [7:0]    wbyte;
        logic [7:0]    rbyte;
    } t_bus_op;

    typedef struct {
        logic [7:0] read_byte;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       dropped;
        logic       tx_pend;
        logic       rx_pend;
    } t_uart_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = uf_pkg::KIND_BUS_RD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    t_bus_op    bus_ops_q[$];
    t_uart_resp resp_q[$];

    // model copy of both FIFOs
    logic [7:0] rx_mem[DEPTH];
    logic [7:0] tx_mem[DEPTH];
    int         rx_cnt = 0;
    int         rx_hd = 0;
    int         tx_cnt = 0;
    int         tx_hd = 0;

    bit          s_fire = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          n_err = 0;
    int          cycles = 0;
    t_uart_resp  want;
    t_uart_resp  got;
    t_bus_op     op_in;

    uart_fifo_register_model_unit #(
        .FIFO_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_uart_resp step_uart(input t_bus_op op);
        t_uart_resp r;
        r = '{default: '0};
        case (op.kind)
            uf_pkg::KIND_BUS_RD: begin
                if (op.len != 0) begin
                    if (op.offset == uf_pkg::DATA_OFFSET) begin
                        if (rx_cnt != 0) begin
                            r.read_byte = rx_mem[rx_hd];
                            rx_hd = (rx_hd + 1) % DEPTH;
                            rx_cnt--;
                        end
                    end else if (op.offset == uf_pkg::STATUS_OFFSET) begin
                        if (tx_cnt < DEPTH)
                            r.read_byte |= uf_pkg::STATUS_TX_ROOM;
                        if (rx_cnt != 0)
                            r.read_byte |= uf_pkg::STATUS_RX_DATA;
                    end
                end
            end
            uf_pkg::KIND_BUS_WR: begin
                if (op.len != 0 && op.offset == uf_pkg::DATA_OFFSET) begin
                    if (tx_cnt >= DEPTH) begin
                        r.dropped = 1'b1;
                    end else begin
                        tx_mem[(tx_hd + tx_cnt) % DEPTH] = op.wbyte;
                        tx_cnt++;
                    end
                end
            end
            uf_pkg::KIND_RX_PUSH: begin
                if (rx_cnt >= DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    rx_mem[(rx_hd + rx_cnt) % DEPTH] = op.rbyte;
                    rx_cnt++;
                end
            end
            default: begin
                if (tx_cnt != 0) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = tx_mem[tx_hd];
                    tx_hd = (tx_hd + 1) % DEPTH;
                    tx_cnt--;
                end
            end
        endcase
        r.tx_pend = (tx_cnt != 0);
        r.rx_pend = (rx_cnt != 0);
        return r;
    endfunction

    function automatic t_bus_op mk_op(input uf_pkg::t_kind k, input logic [11:0] off,
                                      input logic [3:0] len, input logic [7:0] wb,
                                      input logic [7:0] rb);
        t_bus_op op;
        op.kind   = k;
        op.offset = off;
        op.len    = len;
        op.wbyte  = wb;
        op.rbyte  = rb;
        return op;
    endfunction

    // mode: 0 fill TX, 1 fill RX, 2 drain, 3 mixed, 4 noise
    function automatic t_bus_op rand_op(input int mode);
        t_bus_op op;
        int      r;
        int      k;
        r = $urandom_range(0, 99);
        case (mode)
            0:       k = (r < 70) ? 1 : (r < 80) ? 3 : (r < 90) ? 0 : 2;
            1:       k = (r < 70) ? 2 : (r < 80) ? 0 : (r < 90) ? 1 : 3;
            2:       k = (r < 45) ? 0 : (r < 90) ? 3 : (r < 95) ? 1 : 2;
            default: k = r % 4;
        endcase
        op.kind  = uf_pkg::t_kind'(k);
        op.wbyte = 8'($urandom);
        op.rbyte = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 5)
            op.len = 4'd0;
        else if (r < 80)
            op.len = 4'($urandom_range(1, 8));
        else
            op.len = 4'($urandom_range(9, 15));
        r = $urandom_range(0, 99);
        if (mode == 4 || r >= 88)
            op.offset = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 4095))
                                                    : 12'($urandom_range(1, 8));
        else if (op.kind == uf_pkg::KIND_BUS_RD && r < 30)
            op.offset = uf_pkg::STATUS_OFFSET;
        else
            op.offset = uf_pkg::DATA_OFFSET;
        return op;
    endfunction

    // source side: hold until transfer, then next op or an idle burst
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || s_fire)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (bus_ops_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (bus_ops_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(1, 11) - 1;
                s_tvalid <= 1'b0;
            end else begin
                op_in = bus_ops_q.pop_front();
                s_tdata  <= {op_in.rbyte, op_in.wbyte, op_in.len, op_in.offset};
                s_tuser  <= op_in.kind;
                s_tvalid <= 1'b1;
            end
        end
    end

    // sink side back-pressure
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else if (bus_ops_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        s_fire = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (resp_q.size() == 0) begin
                $error("unexpected result transfer: tdata %06h", m_tdata);
                n_err++;
            end else begin
                want = resp_q.pop_front();
                got.read_byte = m_tdata[7:0];
                got.tx_byte   = m_tdata[15:8];
                got.tx_valid  = m_tdata[16];
                got.dropped   = m_tdata[17];
                got.tx_pend   = m_tdata[18];
                got.rx_pend   = m_tdata[19];
                if (got.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %02h, got %02h", want.read_byte, got.read_byte);
                    n_err++;
                end
                if (got.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
                    n_err++;
                end
                if (got.tx_valid !== want.tx_valid) begin
                    $error("tx_byte_valid: expected %0b, got %0b", want.tx_valid, got.tx_valid);
                    n_err++;
                end
                if (got.dropped !== want.dropped) begin
                    $error("byte_dropped: expected %0b, got %0b", want.dropped, got.dropped);
                    n_err++;
                end
                if (got.tx_pend !== want.tx_pend) begin
                    $error("tx_pending: expected %0b, got %0b", want.tx_pend, got.tx_pend);
                    n_err++;
                end
                if (got.rx_pend !== want.rx_pend) begin
                    $error("rx_pending: expected %0b, got %0b", want.rx_pend, got.rx_pend);
                    n_err++;
                end
            end
        end
        if (s_fire)
            resp_q.push_back(step_uart('{uf_pkg::t_kind'(s_tuser), s_tdata[11:0],
                                         s_tdata[15:12], s_tdata[23:16], s_tdata[31:24]}));
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[uart_fifo_register_model_unit] ERROR");
            $finish;
        end
    end

    initial begin
        int seg_len;
        int mode;

        // directed: empty state, zero length, odd offsets, both FIFOs
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::STATUS_OFFSET, 4'd1,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::DATA_OFFSET,   4'd1,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_TX_POP,  uf_pkg::DATA_OFFSET,   4'd0,
                                  8'hFF, 8'hFF));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::DATA_OFFSET,   4'd0,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::STATUS_OFFSET, 4'd0,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_WR,  uf_pkg::DATA_OFFSET,   4'd0,
                                  8'hA5, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_WR,  uf_pkg::STATUS_OFFSET, 4'd1,
                                  8'h5A, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  12'hFFF,               4'd15,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_WR,  12'hFFF,               4'd8,
                                  8'hFF, 8'hFF));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_RX_PUSH, 12'hFFF,               4'd15,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_RX_PUSH, uf_pkg::DATA_OFFSET,   4'd0,
                                  8'h00, 8'hFF));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::STATUS_OFFSET, 4'd8,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::DATA_OFFSET,   4'd8,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::DATA_OFFSET,   4'd15,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_WR,  uf_pkg::DATA_OFFSET,   4'd1,
                                  8'hFF, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_WR,  uf_pkg::DATA_OFFSET,   4'd15,
                                  8'h00, 8'hFF));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::STATUS_OFFSET, 4'd1,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_TX_POP,  uf_pkg::DATA_OFFSET,   4'd0,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_TX_POP,  12'hFFF,               4'd15,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_TX_POP,  uf_pkg::DATA_OFFSET,   4'd0,
                                  8'h00, 8'h00));
        bus_ops_q.push_back(mk_op(uf_pkg::KIND_BUS_RD,  uf_pkg::DATA_OFFSET,   4'd1,
                                  8'h00, 8'h00));

        // random segments; fill phases run long enough to reach the full case
        while (bus_ops_q.size() < N_ITEMS) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 2) ? 0 : (mode < 4) ? 1 : (mode < 6) ? 2 : (mode < 9) ? 3 : 4;
            seg_len = (mode <= 1) ? $urandom_range(20, 40) : $urandom_range(8, 30);
            repeat (seg_len) begin
                if (bus_ops_q.size() < N_ITEMS)
                    bus_ops_q.push_back(rand_op(mode));
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_ops_q.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (resp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_err == 0)
            $display("[uart_fifo_register_model_unit] OK");
        else
            $display("[uart_fifo_register_model_unit] ERROR");
        $finish;
    end

endmodule
